// File: rtl/stereo_gain_median_filter_assert.svh
// assertion macros for the stereo gain median filter
`ifndef STEREO_GAIN_MEDIAN_FILTER_ASSERT_SVH
`define STEREO_GAIN_MEDIAN_FILTER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define SGMF_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SGMF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/sgmf_pkg.sv
// shared types and constants for the stereo gain median filter
package sgmf_pkg;

   localparam int SampleWidth  = 16;
   localparam int GainWidth    = 17;
   localparam int ProductWidth = SampleWidth + GainWidth + 1;
   localparam int FracBits     = 16;
   localparam int QuotWidth    = ProductWidth - FracBits;
   localparam int QueueDepth   = 2;

   localparam logic signed [QuotWidth-1:0] SatHi = QuotWidth'(32767);
   localparam logic signed [QuotWidth-1:0] SatLo = -QuotWidth'(32768);

   typedef logic signed [SampleWidth-1:0] sample_type;
   typedef logic [GainWidth-1:0]          gain_type;

   typedef struct packed {
      sample_type left;
      sample_type right;
      logic       last;
   } frame_type;

   typedef struct packed {
      logic load;
      logic fire;
      logic pending_valid;
      logic pending_is_first;
      logic last;
   } lane_ctl_type;

   typedef struct packed {
      logic fire;
      logic has_held;
      logic last;
   } push_type;

endpackage

// File: rtl/sgmf_req_if.sv
// request channel carrying one stereo frame with gain and buffer end mark
interface sgmf_req_if;
   logic                 valid;
   logic                 ready;
   sgmf_pkg::sample_type left_sample;
   sgmf_pkg::sample_type right_sample;
   sgmf_pkg::gain_type   gain;
   logic                 last_in_buffer;

   modport source (output valid, left_sample, right_sample, gain, last_in_buffer,
                   input ready);
   modport sink (input valid, left_sample, right_sample, gain, last_in_buffer,
                 output ready);
endinterface

// File: rtl/sgmf_rsp_if.sv
// response channel carrying one filtered stereo frame
interface sgmf_rsp_if;
   logic                 valid;
   logic                 ready;
   sgmf_pkg::sample_type left_out;
   sgmf_pkg::sample_type right_out;
   logic                 last_out;

   modport source (output valid, left_out, right_out, last_out, input ready);
   modport sink (input valid, left_out, right_out, last_out, output ready);
endinterface

// File: rtl/stereo_gain_median_filter.sv
// top level: stereo gain with a three tap median filter per channel
//
// Channels: req_ch takes one stereo frame per request (two signed 16-bit
// samples, a 17-bit unsigned Q1.16 gain, and a mark on the last frame of a buffer).
// rsp_ch returns filtered frames with last_out on the final frame of a buffer.
// Both use valid/ready; a transfer happens on a clock edge with both high.
// The first frame of a buffer is held and yields no response at once; every
// later frame releases the held one, and the last frame also releases itself,
// so it yields two responses. A one-frame buffer yields one response.
// Responses caused by a request pass the multiply stage register, then the
// median and merge stage into the queue. Throughput: one request per cycle
// while the queue has room; the two-entry response queue absorbs the extra
// response of a buffer end, limited by the single response port.
// Reset clears the held frame state, empties the queue and drops valid.
// When the receiver stalls, the queue fills and req_ch.ready drops until the
// queue has room for the responses of the frame in the multiply stage.
`include "stereo_gain_median_filter_assert.svh"

module stereo_gain_median_filter (
   input  logic        clock,
   input  logic        reset,
   sgmf_req_if.sink    req_ch,
   sgmf_rsp_if.source  rsp_ch
);
   import sgmf_pkg::*;

   logic         s1_valid_ff, s1_valid_in;
   logic         s1_last_ff, s1_last_in;
   logic         pend_valid_ff, pend_valid_in;
   logic         pend_first_ff, pend_first_in;
   logic         req_fire;
   logic         s2_fire;
   logic [1:0]   n_needed;
   logic [1:0]   room;
   lane_ctl_type ctl;
   push_type     push;
   sample_type   left_filt, left_scaled, right_filt, right_scaled;
   frame_type    held_frame, last_frame;

   assign n_needed     = {1'b0, pend_valid_ff} + {1'b0, s1_last_ff};
   assign s2_fire      = s1_valid_ff && (n_needed <= room);
   assign req_ch.ready = !s1_valid_ff || s2_fire;
   assign req_fire     = req_ch.valid && req_ch.ready;

   always_comb begin
      ctl.load             = req_fire;
      ctl.fire             = s2_fire;
      ctl.pending_valid    = pend_valid_ff;
      ctl.pending_is_first = pend_first_ff;
      ctl.last             = s1_last_ff;
      push.fire            = s2_fire;
      push.has_held        = pend_valid_ff;
      push.last            = s1_last_ff;
   end

   sgmf_lane u_lane_left (
      .clock     (clock),
      .reset     (reset),
      .sample_in (req_ch.left_sample),
      .gain_in   (req_ch.gain),
      .ctl       (ctl),
      .filtered  (left_filt),
      .scaled    (left_scaled)
   );

   sgmf_lane u_lane_right (
      .clock     (clock),
      .reset     (reset),
      .sample_in (req_ch.right_sample),
      .gain_in   (req_ch.gain),
      .ctl       (ctl),
      .filtered  (right_filt),
      .scaled    (right_scaled)
   );

   always_comb begin
      held_frame.left  = left_filt;
      held_frame.right = right_filt;
      held_frame.last  = 1'b0;
      last_frame.left  = left_scaled;
      last_frame.right = right_scaled;
      last_frame.last  = 1'b1;
   end

   sgmf_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .held_frame (held_frame),
      .last_frame (last_frame),
      .room       (room),
      .rsp_ch     (rsp_ch)
   );

   always_comb begin
      s1_valid_in   = s1_valid_ff;
      s1_last_in    = s1_last_ff;
      pend_valid_in = pend_valid_ff;
      pend_first_in = pend_first_ff;
      if (s2_fire) begin
         s1_valid_in = 1'b0;
         if (s1_last_ff) begin
            pend_valid_in = 1'b0;
            pend_first_in = 1'b0;
         end else if (pend_valid_ff) begin
            pend_first_in = 1'b0;
         end else begin
            pend_valid_in = 1'b1;
            pend_first_in = 1'b1;
         end
      end
      if (req_fire) begin
         s1_valid_in = 1'b1;
         s1_last_in  = req_ch.last_in_buffer;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s1_last_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
         pend_first_ff <= 1'b0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         s1_last_ff    <= s1_last_in;
         pend_valid_ff <= pend_valid_in;
         pend_first_ff <= pend_first_in;
      end
   end

   `SGMF_ASSERT_SAME(a_no_overrun, req_fire && s1_valid_ff, s2_fire, "multiply stage overrun")
   `SGMF_ASSERT_SAME(a_first_needs_held, pend_first_ff, pend_valid_ff, "first flag without frame")
   `SGMF_ASSERT_NEXT(a_end_flushes, s2_fire && s1_last_ff, !pend_valid_ff, "buffer end not flushed")

endmodule

// File: rtl/sgmf_lane.sv
// one channel lane: gain multiply, truncate and saturate, three tap median
module sgmf_lane (
   input  logic                   clock,
   input  logic                   reset,
   input  sgmf_pkg::sample_type   sample_in,
   input  sgmf_pkg::gain_type     gain_in,
   input  sgmf_pkg::lane_ctl_type ctl,
   output sgmf_pkg::sample_type   filtered,
   output sgmf_pkg::sample_type   scaled
);
   import sgmf_pkg::*;

   logic signed [ProductWidth-1:0] product_ff, product_in;
   logic signed [QuotWidth-1:0]    quot;
   logic signed [QuotWidth-1:0]    quot_fixed;
   sample_type                     prev_ff, prev_in;
   sample_type                     pend_ff, pend_in;
   sample_type                     lo_ab, hi_ab, med;

   assign product_in = ProductWidth'(sample_in) *
                       ProductWidth'($signed({1'b0, gain_in}));

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         product_ff <= product_in;
      end
   end

   // arithmetic shift floors, so bump negatives with a fraction toward zero
   always_comb begin
      quot = QuotWidth'(product_ff >>> FracBits);
      quot_fixed = quot;
      if (product_ff[ProductWidth-1] && (product_ff[FracBits-1:0] != '0)) begin
         quot_fixed = quot + QuotWidth'(1);
      end
      if (quot_fixed > SatHi) begin
         scaled = SampleWidth'(SatHi);
      end else if (quot_fixed < SatLo) begin
         scaled = SampleWidth'(SatLo);
      end else begin
         scaled = SampleWidth'(quot_fixed);
      end
   end

   always_comb begin
      lo_ab = (prev_ff < pend_ff) ? prev_ff : pend_ff;
      hi_ab = (prev_ff < pend_ff) ? pend_ff : prev_ff;
      med   = (hi_ab < scaled) ? hi_ab : scaled;
      med   = (lo_ab > med) ? lo_ab : med;
      filtered = ctl.pending_is_first ? pend_ff : med;
   end

   always_comb begin
      prev_in = prev_ff;
      pend_in = pend_ff;
      if (ctl.fire) begin
         if (ctl.pending_valid) begin
            prev_in = filtered;
         end
         pend_in = scaled;
         if (ctl.last) begin
            prev_in = scaled;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
         pend_ff <= '0;
      end else begin
         prev_ff <= prev_in;
         pend_ff <= pend_in;
      end
   end

endmodule

// File: rtl/sgmf_merge.sv
// merges both lanes into frames and queues up to two for the response side
module sgmf_merge (
   input  logic                 clock,
   input  logic                 reset,
   input  sgmf_pkg::push_type   push,
   input  sgmf_pkg::frame_type  held_frame,
   input  sgmf_pkg::frame_type  last_frame,
   output logic [1:0]           room,
   sgmf_rsp_if.source           rsp_ch
);
   import sgmf_pkg::*;

   frame_type  q_ff [QueueDepth];
   frame_type  q_in [QueueDepth];
   logic [1:0] cnt_ff, cnt_in;
   logic [1:0] base;
   logic [1:0] n_push;
   logic       pop;
   frame_type  new0;

   assign pop          = rsp_ch.valid && rsp_ch.ready;
   assign rsp_ch.valid = (cnt_ff != 2'd0);
   assign rsp_ch.left_out  = q_ff[0].left;
   assign rsp_ch.right_out = q_ff[0].right;
   assign rsp_ch.last_out  = q_ff[0].last;

   assign room = 2'(QueueDepth) - cnt_ff + {1'b0, pop};

   always_comb begin
      n_push = push.fire ? ({1'b0, push.has_held} + {1'b0, push.last}) : 2'd0;
      base   = cnt_ff - {1'b0, pop};
      new0   = push.has_held ? held_frame : last_frame;
      q_in   = q_ff;
      if (pop) begin
         q_in[0] = q_ff[1];
      end
      // slots past the surviving entries take the new frames in order
      for (int i = 0; i < QueueDepth; i++) begin
         if (2'(i) == base) begin
            q_in[i] = new0;
         end else if (2'(i) > base) begin
            q_in[i] = last_frame;
         end
      end
      cnt_in = base + n_push;
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

// File: dv/stereo_gain_median_filter_test.sv
// self-checking testbench for the stereo gain median filter
module stereo_gain_median_filter_test;
   import sgmf_pkg::*;

   localparam int CycleLimit  = 400000;
   localparam int DrainCycles = 20;
   localparam int MaxReported = 10;

   logic clock = 1'b0;
   logic reset;

   sgmf_req_if req_ch ();
   sgmf_rsp_if rsp_ch ();

   stereo_gain_median_filter dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // filter state as the block should hold it
   sample_type prev_left, prev_right;
   sample_type held_left, held_right;
   logic       held_valid, held_first;
   frame_type  expected_frames[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_left     = 0;
   int error_count   = 0;
   int cycle_count   = 0;

   function automatic sample_type apply_gain(sample_type s, gain_type g);
      longint prod;
      longint quot;
      prod = longint'(s) * longint'(g);
      quot = prod / 65536;  // truncates toward zero
      if (quot > 32767) quot = 32767;
      if (quot < -32768) quot = -32768;
      return sample_type'(quot);
   endfunction

   function automatic sample_type median_of3(sample_type a, sample_type b, sample_type c);
      sample_type t;
      if (a > b) begin
         t = a; a = b; b = t;
      end
      if (b > c) begin
         t = b; b = c; c = t;
      end
      if (a > b) b = a;
      return b;
   endfunction

   function automatic void filter_frame(sample_type l, sample_type r, gain_type g,
                                        logic last);
      sample_type cur_l, cur_r, out_l, out_r;
      cur_l = apply_gain(l, g);
      cur_r = apply_gain(r, g);
      if (held_valid) begin
         if (held_first) begin
            out_l = held_left;
            out_r = held_right;
         end else begin
            out_l = median_of3(prev_left, held_left, cur_l);
            out_r = median_of3(prev_right, held_right, cur_r);
         end
         prev_left  = out_l;
         prev_right = out_r;
         expected_frames.push_back('{left: out_l, right: out_r, last: 1'b0});
         held_first = 1'b0;
      end else begin
         held_valid = 1'b1;
         held_first = 1'b1;
      end
      held_left  = cur_l;
      held_right = cur_r;
      if (last) begin
         expected_frames.push_back('{left: cur_l, right: cur_r, last: 1'b1});
         prev_left  = cur_l;
         prev_right = cur_r;
         held_valid = 1'b0;
         held_first = 1'b0;
      end
   endfunction

   task automatic report_error(string what, frame_type want, frame_type got);
      error_count++;
      if (error_count <= MaxReported)
         $display("%s: expected L=%0d R=%0d last=%0b, got L=%0d R=%0d last=%0b",
                  what, want.left, want.right, want.last, got.left, got.right, got.last);
   endtask

   // check responses first, then predict the request taken at the same edge
   always @(posedge clock) begin
      frame_type got, want;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{left: rsp_ch.left_out, right: rsp_ch.right_out, last: rsp_ch.last_out};
            if (expected_frames.size() == 0) begin
               report_error("unexpected response", '0, got);
            end else begin
               want = expected_frames.pop_front();
               if (got.left !== want.left || got.right !== want.right ||
                   got.last !== want.last)
                  report_error("response differs", want, got);
            end
         end
         if (req_ch.valid && req_ch.ready)
            filter_frame(req_ch.left_sample, req_ch.right_sample, req_ch.gain,
                         req_ch.last_in_buffer);
      end
   end

   // receiver: random stalls, or a long hold-off when one is asked for
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("stereo_gain_median_filter: mismatch");
         $finish;
      end
   end

   task automatic send_frame(sample_type l, sample_type r, gain_type g, logic last);
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid          <= 1'b0;
         req_ch.left_sample    <= sample_type'($urandom);
         req_ch.right_sample   <= sample_type'($urandom);
         req_ch.gain           <= gain_type'($urandom);
         req_ch.last_in_buffer <= 1'($urandom);
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.left_sample    <= l;
      req_ch.right_sample   <= r;
      req_ch.gain           <= g;
      req_ch.last_in_buffer <= last;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   function automatic sample_type pick_sample(sample_type prev);
      case ($urandom_range(7))
         0: return sample_type'(32767);
         1: return sample_type'(-32768);
         2, 3: return sample_type'($urandom);
         default: return sample_type'(int'(prev) + $signed($urandom_range(0, 2000)) - 1000);
      endcase
   endfunction

   function automatic gain_type pick_gain();
      case ($urandom_range(5))
         0: return gain_type'(65536);
         1: return $urandom_range(1) ? gain_type'(0) : gain_type'(131071);
         2: return gain_type'($urandom_range(65537, 131071));
         default: return gain_type'($urandom_range(0, 65536));
      endcase
   endfunction

   task automatic test_single_frame_buffers();
      send_frame(16'sd32767, -16'sd32768, 17'd65536, 1'b1);
      send_frame(-16'sd32768, 16'sd32767, 17'd131071, 1'b1);
      send_frame(16'sd1234, -16'sd1, 17'd0, 1'b1);
   endtask

   task automatic test_two_frame_buffer();
      send_frame(16'sd100, -16'sd200, 17'd65536, 1'b0);
      send_frame(-16'sd300, 16'sd400, 17'd32768, 1'b1);
   endtask

   task automatic test_gain_extremes();
      // zero, one lsb, unity and the largest gain, with saturation on the last
      send_frame(16'sd32767, -16'sd32768, 17'd0, 1'b0);
      send_frame(16'sd32767, -16'sd32768, 17'd1, 1'b0);
      send_frame(-16'sd1, 16'sd1, 17'd65535, 1'b0);
      send_frame(16'sd32767, -16'sd32768, 17'd65536, 1'b0);
      send_frame(16'sd32767, -16'sd32768, 17'd131071, 1'b0);
      send_frame(16'sd20000, -16'sd20000, 17'd131071, 1'b1);
   endtask

   task automatic test_median_impulses();
      // isolated spikes should be removed by the median
      send_frame(16'sd100, -16'sd100, 17'd65536, 1'b0);
      send_frame(16'sd32767, -16'sd32768, 17'd65536, 1'b0);
      send_frame(16'sd120, -16'sd120, 17'd65536, 1'b0);
      send_frame(-16'sd32768, 16'sd32767, 17'd65536, 1'b0);
      send_frame(16'sd140, -16'sd140, 17'd65536, 1'b0);
      send_frame(16'sd90, -16'sd90, 17'd65536, 1'b0);
      send_frame(16'sd32767, 16'sd32767, 17'd65536, 1'b1);
   endtask

   task automatic test_random_buffers(int frames, int send_pct, int recv_pct);
      int         sent;
      int         len;
      gain_type   g;
      sample_type l, r;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      sent = 0;
      l = '0;
      r = '0;
      while (sent < frames) begin
         case ($urandom_range(9))
            0: len = 1;
            1: len = 2;
            default: len = $urandom_range(3, 16);
         endcase
         g = pick_gain();
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(7) == 0) g = pick_gain();
            l = pick_sample(l);
            r = pick_sample(r);
            send_frame(l, r, g, i == len - 1);
            sent++;
         end
      end
   endtask

   task automatic test_receiver_hold_off();
      // long stall on the response side fills the queue and blocks requests
      hold_left = 300;
      test_random_buffers(60, 0, 0);
   endtask

   initial begin
      reset                 <= 1'b1;
      req_ch.valid          <= 1'b0;
      req_ch.left_sample    <= '0;
      req_ch.right_sample   <= '0;
      req_ch.gain           <= '0;
      req_ch.last_in_buffer <= 1'b0;
      prev_left  = '0;
      prev_right = '0;
      held_left  = '0;
      held_right = '0;
      held_valid = 1'b0;
      held_first = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 13;
      recv_idle_pct = 59;
      test_single_frame_buffers();
      test_two_frame_buffer();
      test_gain_extremes();
      test_median_impulses();
      test_random_buffers(360, 13, 59);
      test_random_buffers(360, 59, 13);
      test_random_buffers(360, 0, 0);
      test_receiver_hold_off();

      req_ch.valid <= 1'b0;
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0 && expected_frames.size() == 0) begin
         $display("stereo_gain_median_filter: match");
      end else begin
         $display("stereo_gain_median_filter: mismatch");
      end
      $finish;
   end

endmodule
